// ===== design/tlbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbf_pkg
// Shared codes and field widths for the two-level bitmap find-next block.
// ----------------------------------------------------------------------------
package tlbf_pkg;

   localparam int REQ_W       = 2;
   localparam int INDEX_W     = 12;
   localparam int STATUS_W    = 2;
   localparam int BIT_COUNT_W = 13;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   typedef logic [REQ_W-1:0]    req_code_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam req_code_type REQ_INSERT = 2'd0;
   localparam req_code_type REQ_REMOVE = 2'd1;
   localparam req_code_type REQ_FIND   = 2'd2;
   localparam req_code_type REQ_CLEAR  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_NONE  = 2'd2;

   // register index, taken from the word address bit of the CSR port
   localparam logic CSR_BIT_COUNT = 1'b0;

   localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RESET = 13'd4096;

endpackage

// ===== design/tlbf_ram.sv =====
// ----------------------------------------------------------------------------
// tlbf_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tlbf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tlbf_csr.sv =====
// ----------------------------------------------------------------------------
// tlbf_csr
// APB-style register file holding bit_count; decodes the in-use word mask.
// ----------------------------------------------------------------------------
module tlbf_csr #(
   parameter int WORD_BITS = 64,
   parameter int NUM_WORDS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tlbf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tlbf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tlbf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [NUM_WORDS-1:0]             word_in_use
);

   logic [tlbf_pkg::BIT_COUNT_W-1:0] bit_count_ff;
   logic [tlbf_pkg::BIT_COUNT_W-1:0] bit_count_in;
   logic                             sel_bit_count;

   assign sel_bit_count = (csr_paddr[tlbf_pkg::CSR_ADDR_W-1] == tlbf_pkg::CSR_BIT_COUNT);

   always_comb begin
      bit_count_in = bit_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_bit_count) begin
         bit_count_in = csr_pwdata[tlbf_pkg::BIT_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= tlbf_pkg::BIT_COUNT_RESET;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_bit_count ?
      tlbf_pkg::CSR_DATA_W'(bit_count_ff) : '0;

   // word k is in use when its first bit lies below bit_count
   for (genvar k = 0; k < NUM_WORDS; k++) begin : g_use
      localparam logic [tlbf_pkg::BIT_COUNT_W-1:0] BASE =
         tlbf_pkg::BIT_COUNT_W'(k * WORD_BITS);
      assign word_in_use[k] = (BASE < bit_count_ff);
   end

endmodule

// ===== design/two_level_bitmap_find_next_top.sv =====
// ----------------------------------------------------------------------------
// two_level_bitmap_find_next_top
// A request is accepted in idle and executed from a registered word read; a find
// that moves to a later word reads that word in a further state before responding.
// A new request is taken only once the previous one has finished (req_ready is high
// only in idle), and execute stalls while the response register is still full.
// Reset: synchronous; clears the summary word (so every stored word reads as
// zero), the sequencer and the response valid flag, and sets bit_count to 4096.
// Clear zeroes the summary word; the RAM is not swept.
// ----------------------------------------------------------------------------
module two_level_bitmap_find_next_top #(
   parameter int WORD_BITS = 64,
   parameter int NUM_WORDS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tlbf_pkg::REQ_W-1:0]       req_type,
   input  logic [tlbf_pkg::INDEX_W-1:0]     req_bit_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tlbf_pkg::STATUS_W-1:0]    rsp_status,
   output logic [tlbf_pkg::INDEX_W-1:0]     rsp_found_index,
   output logic                             rsp_is_empty,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tlbf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tlbf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tlbf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int BIT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int WORD_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int INDEX_W = tlbf_pkg::INDEX_W;
   localparam logic [INDEX_W:0] CAPACITY = (INDEX_W + 1)'(WORD_BITS * NUM_WORDS);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_FIND2 = 2'd2;

   function automatic logic [BIT_W-1:0] low_bit_word(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] low_bit_summary(input logic [NUM_WORDS-1:0] v);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = WORD_W'(i);
         end
      end
      return r;
   endfunction

   // configuration
   logic [NUM_WORDS-1:0] word_in_use;

   tlbf_csr #(
      .WORD_BITS (WORD_BITS),
      .NUM_WORDS (NUM_WORDS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .word_in_use (word_in_use)
   );

   // state and request registers
   logic [1:0]                  state_ff, state_in;
   logic [NUM_WORDS-1:0]        summary_ff, summary_in;
   tlbf_pkg::req_code_type      op_ff;
   logic [WORD_W-1:0]           word_ff;
   logic [BIT_W-1:0]            bit_ff;
   logic [INDEX_W-1:0]          base_ff;
   logic                        in_range_ff;
   logic [WORD_W-1:0]           t_ff, t_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   tlbf_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]          rsp_found_ff, rsp_found_in;
   logic                        rsp_empty_ff, rsp_empty_in;

   // request decode
   logic                        accept;
   logic [WORD_W-1:0]           req_word;
   logic [INDEX_W-1:0]          req_base;
   logic [BIT_W-1:0]            req_bit;
   logic                        req_in_range;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      req_word = '0;
      for (int k = 1; k < NUM_WORDS; k++) begin
         if (req_bit_index >= INDEX_W'(k * WORD_BITS)) begin
            req_word = WORD_W'(k);
         end
      end
      req_base     = INDEX_W'(int'(req_word) * WORD_BITS);
      req_bit      = BIT_W'(req_bit_index - req_base);
      req_in_range = ({1'b0, req_bit_index} < CAPACITY) && word_in_use[req_word];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= tlbf_pkg::req_code_type'(req_type);
         word_ff     <= req_word;
         bit_ff      <= req_bit;
         base_ff     <= req_base;
         in_range_ff <= req_in_range;
      end
      t_ff <= t_in;
   end

   // word RAM
   logic                 ram_wr_en;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [WORD_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   tlbf_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // execute
   logic                 out_free;
   logic [WORD_BITS-1:0] word_cur;
   logic [WORD_BITS-1:0] bit_onehot;
   logic [WORD_BITS-1:0] cur_above;
   logic [NUM_WORDS-1:0] cand;
   logic [WORD_W-1:0]    cand_word;
   logic                 go_find2;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   // a word whose summary bit is clear holds stale data: read it as zero
   assign word_cur   = summary_ff[word_ff] ? ram_rd_data : '0;
   assign bit_onehot = WORD_BITS'(1) << bit_ff;
   assign cur_above  = word_cur & ({WORD_BITS{1'b1}} << bit_ff);
   assign cand       = summary_ff & word_in_use & (({NUM_WORDS{1'b1}} << word_ff) << 1);
   assign cand_word  = low_bit_summary(cand);
   assign go_find2   = (state_ff == S_EXEC) && (op_ff == tlbf_pkg::REQ_FIND) &&
                       in_range_ff && (cur_above == '0) && (cand != '0);

   assign ram_rd_en   = accept || go_find2;
   assign ram_rd_addr = accept ? req_word : cand_word;

   always_comb begin
      state_in      = state_ff;
      summary_in    = summary_ff;
      t_in          = t_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = word_cur;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_empty_in  = rsp_empty_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (go_find2) begin
               t_in     = cand_word;
               state_in = S_FIND2;
            end else if (out_free) begin
               rsp_status_in = tlbf_pkg::ST_OK;
               rsp_found_in  = '0;
               unique case (op_ff)
                  tlbf_pkg::REQ_CLEAR: begin
                     summary_in = '0;
                  end
                  tlbf_pkg::REQ_INSERT: begin
                     if (in_range_ff) begin
                        ram_wr_en           = 1'b1;
                        ram_wr_data         = word_cur | bit_onehot;
                        summary_in[word_ff] = 1'b1;
                     end
                  end
                  tlbf_pkg::REQ_REMOVE: begin
                     if (in_range_ff) begin
                        ram_wr_en           = 1'b1;
                        ram_wr_data         = word_cur & ~bit_onehot;
                        summary_in[word_ff] = |(word_cur & ~bit_onehot);
                     end
                  end
                  tlbf_pkg::REQ_FIND: begin
                     if (in_range_ff && (cur_above != '0)) begin
                        rsp_found_in = base_ff + INDEX_W'(low_bit_word(cur_above));
                     end else if (in_range_ff) begin
                        rsp_status_in = tlbf_pkg::ST_NONE;
                     end
                  end
               endcase
               if (!in_range_ff && (op_ff != tlbf_pkg::REQ_CLEAR)) begin
                  rsp_status_in = tlbf_pkg::ST_RANGE;
               end
               rsp_valid_in = 1'b1;
               rsp_empty_in = (summary_in == '0);
               state_in     = S_IDLE;
            end
         end
         S_FIND2: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = tlbf_pkg::ST_OK;
               rsp_found_in  = INDEX_W'(int'(t_ff) * WORD_BITS) +
                               INDEX_W'(low_bit_word(ram_rd_data));
               rsp_empty_in  = (summary_ff == '0);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         summary_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter execute");

   a_find2_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND2) |-> summary_ff[t_ff])
      else $error("second find read targets an empty word");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EXEC || $past(state_ff) == S_FIND2))
      else $error("response raised outside execute or second read");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != tlbf_pkg::ST_OK)) |-> (rsp_found_ff == '0))
      else $error("failed request returned a non-zero index");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level bitmap find-next block. Requests
// (insert, remove, find next set, clear all) are checked against a software
// copy of the word store and summary word under several bit_count settings,
// with random idling on both channels and read-back of the size register.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned QUIET_LIMIT = 5000;
   localparam logic [tlbf_pkg::CSR_ADDR_W-1:0] BIT_COUNT_ADDR =
      {tlbf_pkg::CSR_BIT_COUNT, 2'b00};

   typedef struct packed {
      tlbf_pkg::req_code_type          kind;
      logic [tlbf_pkg::INDEX_W-1:0]    index;
      logic                            drain;
   } request_type;

   typedef struct packed {
      tlbf_pkg::status_type            status;
      logic [tlbf_pkg::INDEX_W-1:0]    found;
      logic                            empty;
   } outcome_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   tlbf_pkg::req_code_type              req_type = tlbf_pkg::REQ_INSERT;
   logic [tlbf_pkg::INDEX_W-1:0]        req_bit_index = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [tlbf_pkg::STATUS_W-1:0]       rsp_status;
   logic [tlbf_pkg::INDEX_W-1:0]        rsp_found_index;
   logic                                rsp_is_empty;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [tlbf_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [tlbf_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [tlbf_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   request_type                         pending_reqs [$];
   outcome_type                         expected_rsps [$];
   outcome_type                         oldest;
   bit                                  req_fired = 1'b0;
   int unsigned                         send_idle_pct = 0;
   int unsigned                         recv_idle_pct = 0;
   int unsigned                         quiet_cycles = 0;
   int unsigned                         errors = 0;

   logic [63:0]                         bm_words [64];
   logic [63:0]                         bm_summary = '0;
   logic [tlbf_pkg::BIT_COUNT_W-1:0]    bm_size = tlbf_pkg::BIT_COUNT_RESET;

   two_level_bitmap_find_next_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_bit_index   (req_bit_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_is_empty    (rsp_is_empty),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void note_failure(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic int unsigned lowest_one(input logic [63:0] v);
      for (int unsigned n = 0; n < 64; n++) begin
         if (v[n]) return n;
      end
      return 63;
   endfunction

   function automatic int unsigned words_used();
      int unsigned bc;
      bc = (bm_size > 4096) ? 4096 : bm_size;
      return (bc + 63) / 64;
   endfunction

   // update the bitmap copy and return the response the request must produce
   function automatic outcome_type apply_request(input tlbf_pkg::req_code_type kind,
                                                 input logic [tlbf_pkg::INDEX_W-1:0] idx);
      outcome_type   o;
      int unsigned   nw;
      int unsigned   w;
      int unsigned   b;
      int unsigned   t;
      logic [63:0]   cur;
      logic [63:0]   span_mask;
      logic [63:0]   above;
      logic [63:0]   cand;
      o.status = tlbf_pkg::ST_OK;
      o.found = '0;
      nw = words_used();
      w = idx[11:6];
      b = idx[5:0];
      if (kind == tlbf_pkg::REQ_CLEAR) begin
         foreach (bm_words[i]) bm_words[i] = '0;
         bm_summary = '0;
      end else if (idx >= nw * 64) begin
         o.status = tlbf_pkg::ST_RANGE;
      end else begin
         case (kind)
            tlbf_pkg::REQ_INSERT: begin
               bm_words[w][b] = 1'b1;
               bm_summary[w] = 1'b1;
            end
            tlbf_pkg::REQ_REMOVE: begin
               bm_words[w][b] = 1'b0;
               if (bm_words[w] == '0) bm_summary[w] = 1'b0;
            end
            default: begin
               cur = bm_words[w] >> b;
               if (cur != '0) begin
                  o.found = tlbf_pkg::INDEX_W'(idx + lowest_one(cur));
               end else begin
                  span_mask = (nw >= 64) ? '1 : ((64'd1 << nw) - 64'd1);
                  above = (w + 1 < 64) ? ('1 << (w + 1)) : '0;
                  cand = bm_summary & span_mask & above;
                  if (cand == '0) begin
                     o.status = tlbf_pkg::ST_NONE;
                  end else begin
                     t = lowest_one(cand);
                     o.found = tlbf_pkg::INDEX_W'(t * 64 + lowest_one(bm_words[t]));
                  end
               end
            end
         endcase
      end
      o.empty = (bm_summary == '0);
      return o;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
             !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
            req_valid <= 1'b1;
            req_type <= pending_reqs[0].kind;
            req_bit_index <= pending_reqs[0].index;
            void'(pending_reqs.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor and watchdog
   always @(posedge clock) begin
      req_fired = !reset && req_valid && req_ready;
      if (req_fired) expected_rsps.push_back(apply_request(req_type, req_bit_index));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            note_failure($sformatf("unexpected response status %0d found %0d empty %0b",
                                   rsp_status, rsp_found_index, rsp_is_empty));
         end else begin
            oldest = expected_rsps.pop_front();
            if (rsp_status !== oldest.status || rsp_found_index !== oldest.found ||
                rsp_is_empty !== oldest.empty)
               note_failure($sformatf("status %0d/%0d found %0d/%0d empty %0b/%0b (exp/got)",
                                      oldest.status, rsp_status, oldest.found,
                                      rsp_found_index, oldest.empty, rsp_is_empty));
         end
      end
      if (req_fired || (rsp_valid && rsp_ready) ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL two_level_bitmap_find_next_top");
         $finish;
      end
   end

   task automatic settle();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_request(input tlbf_pkg::req_code_type kind,
                                input int unsigned idx,
                                input bit drain = 1'b0);
      request_type r;
      r.kind = kind;
      r.index = tlbf_pkg::INDEX_W'(idx);
      r.drain = drain;
      pending_reqs.push_back(r);
   endtask

   // write bit_count while idle, then read it back
   task automatic program_size(input int unsigned value);
      settle();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= BIT_COUNT_ADDR;
      csr_pwdata <= tlbf_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      bm_size = tlbf_pkg::BIT_COUNT_W'(value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== tlbf_pkg::CSR_DATA_W'(bm_size))
         note_failure($sformatf("bit_count read %0d, expected %0d", csr_prdata, bm_size));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // mostly traffic on a few hot words so words fill, empty and get searched across
   task automatic queue_random(input int count);
      int unsigned              span;
      int unsigned              pick;
      int unsigned              idx;
      int unsigned              hot [4];
      int unsigned              recent [$];
      tlbf_pkg::req_code_type   kind;
      span = words_used() * 64;
      foreach (hot[i]) hot[i] = (span == 0) ? 0 : $urandom_range(span / 64 - 1);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 38) kind = tlbf_pkg::REQ_INSERT;
         else if (pick < 68) kind = tlbf_pkg::REQ_REMOVE;
         else if (pick < 97) kind = tlbf_pkg::REQ_FIND;
         else kind = tlbf_pkg::REQ_CLEAR;
         pick = $urandom_range(99);
         if (kind == tlbf_pkg::REQ_REMOVE && recent.size() != 0 && pick < 60)
            idx = recent[$urandom_range(recent.size() - 1)];
         else if (span == 0 || pick < 12)
            idx = $urandom_range(4095);
         else if (pick < 22)
            idx = span - 2 + $urandom_range(3);
         else
            idx = hot[$urandom_range(3)] * 64 + $urandom_range(63);
         if (idx > 4095) idx = 4095;
         if (kind == tlbf_pkg::REQ_INSERT) begin
            recent.push_back(idx);
            if (recent.size() > 24) void'(recent.pop_front());
         end
         if (span != 0 && $urandom_range(49) == 0)
            hot[$urandom_range(3)] = $urandom_range(span / 64 - 1);
         queue_request(kind, idx, $urandom_range(99) == 0);
      end
   endtask

   initial begin
      foreach (bm_words[i]) bm_words[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 48;
      program_size(4096);
      queue_request(tlbf_pkg::REQ_FIND, 0);
      queue_request(tlbf_pkg::REQ_INSERT, 0);
      queue_request(tlbf_pkg::REQ_INSERT, 63);
      queue_request(tlbf_pkg::REQ_INSERT, 4095);
      queue_request(tlbf_pkg::REQ_FIND, 1);
      queue_request(tlbf_pkg::REQ_FIND, 64);
      queue_request(tlbf_pkg::REQ_FIND, 4095);
      queue_request(tlbf_pkg::REQ_REMOVE, 63);
      queue_request(tlbf_pkg::REQ_REMOVE, 0);
      queue_request(tlbf_pkg::REQ_FIND, 0);
      queue_request(tlbf_pkg::REQ_INSERT, 64);
      queue_request(tlbf_pkg::REQ_INSERT, 127);
      queue_request(tlbf_pkg::REQ_REMOVE, 64);
      queue_request(tlbf_pkg::REQ_FIND, 65);
      queue_request(tlbf_pkg::REQ_CLEAR, 0);
      queue_request(tlbf_pkg::REQ_FIND, 0);
      queue_request(tlbf_pkg::REQ_INSERT, 3000, 1'b1);

      // shrink with a bit left stored beyond the new size
      program_size(100);
      queue_request(tlbf_pkg::REQ_FIND, 0);
      queue_request(tlbf_pkg::REQ_INSERT, 127);
      queue_request(tlbf_pkg::REQ_INSERT, 128);
      queue_request(tlbf_pkg::REQ_FIND, 100);
      queue_request(tlbf_pkg::REQ_REMOVE, 3000);
      queue_random(200);

      program_size(0);
      queue_request(tlbf_pkg::REQ_INSERT, 0);
      queue_request(tlbf_pkg::REQ_FIND, 0);
      queue_request(tlbf_pkg::REQ_CLEAR, 0);
      queue_random(30);

      send_idle_pct = 48;
      recv_idle_pct = 26;
      program_size(8191);
      queue_random(400);
      program_size(1);
      queue_random(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_size(65);
      queue_random(200);
      program_size(4096);
      queue_random(500);
      program_size(4095);
      queue_random(150);

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS two_level_bitmap_find_next_top");
      else
         $display("FAIL two_level_bitmap_find_next_top");
      $finish;
   end

endmodule
